// ===== rtl/fcull_pkg.sv =====
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types, widths and codes for the frustum culling test pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcull_pkg;

   localparam int NUM_PLANES  = 6;           // planes held in configuration
   localparam int PLANE_COUNT = 6;           // planes tested, 1 .. NUM_PLANES
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int COORD_W     = 16;          // signed Q11.4
   localparam int HALF_W      = 15;          // unsigned Q11.4
   localparam int COEF_W      = 16;          // a,b,c Q1.14, d Q11.4
   localparam int PROD_W      = 2 * COEF_W;  // signed coefficient x coordinate
   localparam int ABSP_W      = HALF_W + COEF_W;
   localparam int FRAC_ALIGN  = 14;          // Q4 to Q18 shift
   localparam int M_W         = PROD_W + 3;  // plane value, signed
   localparam int SLACK_W     = ABSP_W + 2;  // radius or projected half size
   localparam int CMP_W       = M_W + 1;

   localparam logic [1:0] OP_POINT  = 2'd0;
   localparam logic [1:0] OP_SPHERE = 2'd1;
   localparam logic [1:0] OP_BOX    = 2'd2;

   localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

   typedef enum logic [1:0] {
      KIND_POINT,
      KIND_SPHERE,
      KIND_BOX
   } kind_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } stage_en_type;

   // the spare opcode runs the box test
   function automatic kind_type op_to_kind(input logic [1:0] op);
      kind_type k;
      unique case (op)
         OP_POINT:  k = KIND_POINT;
         OP_SPHERE: k = KIND_SPHERE;
         default:   k = KIND_BOX;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/frustum_cull_test.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_test
// Classifies a point, sphere or axis-aligned box against the frustum planes
// held in six 64-bit registers. Each plane runs its own multiply, sum and
// compare stages and a final stage merges the per-plane flags into the
// verdict; the pipeline sustains one transaction per cycle while the result
// side keeps up. Stall from the result side holds only the stages that are
// full; empty stages keep filling, so up to four transactions can wait in
// flight. Opcode 3 runs the box test. Planes are written through the csr
// port, which is always ready; writes to an index past the last plane are
// dropped. Plane registers should be written only while no transaction is
// in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_cull_test (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic signed [fcull_pkg::COORD_W-1:0]  req_center_x,
   input  logic signed [fcull_pkg::COORD_W-1:0]  req_center_y,
   input  logic signed [fcull_pkg::COORD_W-1:0]  req_center_z,
   input  logic [fcull_pkg::HALF_W-1:0]          req_half_x,
   input  logic [fcull_pkg::HALF_W-1:0]          req_half_y,
   input  logic [fcull_pkg::HALF_W-1:0]          req_half_z,
   input  logic [fcull_pkg::HALF_W-1:0]          req_radius,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_verdict,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fcull_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fcull_pkg::CSR_DATA_W-1:0]      csr_data
);
   import fcull_pkg::*;

   logic [CSR_DATA_W-1:0]  plane_ff [NUM_PLANES];

   stage_en_type           stage_en;
   logic                   en4;
   logic                   v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic                   v1_in, v2_in, v3_in, rsp_valid_in;
   kind_type               kind_in, kind1_ff, kind2_ff, kind3_ff;
   logic [PLANE_COUNT-1:0] outside_vec, partial_vec;
   logic                   any_outside, any_partial;
   logic [1:0]             rsp_verdict_ff, rsp_verdict_in;

   // ---------------------------------------------------------------------
   // Plane registers
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_PLANES))) begin
         plane_ff[csr_index] <= csr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Stage enables: a stage moves when it is empty or the next one moves
   // ---------------------------------------------------------------------
   assign en4         = !rsp_valid_ff || !rsp_stall;
   assign stage_en.en3 = !v3_ff || en4;
   assign stage_en.en2 = !v2_ff || stage_en.en3;
   assign stage_en.en1 = !v1_ff || stage_en.en2;
   assign req_stall   = !stage_en.en1;

   assign v1_in        = stage_en.en1 ? req_valid : v1_ff;
   assign v2_in        = stage_en.en2 ? v1_ff     : v2_ff;
   assign v3_in        = stage_en.en3 ? v2_ff     : v3_ff;
   assign rsp_valid_in = en4          ? v3_ff     : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // test kind travels alongside the plane pipelines
   assign kind_in = op_to_kind(req_opcode);

   always_ff @(posedge clock) begin
      if (stage_en.en1) kind1_ff <= kind_in;
      if (stage_en.en2) kind2_ff <= kind1_ff;
      if (stage_en.en3) kind3_ff <= kind2_ff;
   end

   // ---------------------------------------------------------------------
   // One pipeline per plane
   // ---------------------------------------------------------------------
   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fcull_plane u_plane (
         .clock    (clock),
         .stage_en (stage_en),
         .plane    (plane_ff[p]),
         .kind     (kind_in),
         .center_x (req_center_x),
         .center_y (req_center_y),
         .center_z (req_center_z),
         .half_x   (req_half_x),
         .half_y   (req_half_y),
         .half_z   (req_half_z),
         .radius   (req_radius),
         .outside  (outside_vec[p]),
         .partial  (partial_vec[p])
      );
   end

   // ---------------------------------------------------------------------
   // Merge: any rejecting plane wins; partial only counts for boxes
   // ---------------------------------------------------------------------
   assign any_outside = |outside_vec;
   assign any_partial = |partial_vec;

   always_comb begin
      if (any_outside) begin
         rsp_verdict_in = VERDICT_OUTSIDE;
      end else begin
         unique case (kind3_ff)
            KIND_POINT:  rsp_verdict_in = VERDICT_INSIDE;
            KIND_SPHERE: rsp_verdict_in = VERDICT_INTERSECT;
            default:     rsp_verdict_in = any_partial ? VERDICT_INTERSECT : VERDICT_INSIDE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rsp_verdict_ff <= rsp_verdict_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   // a held request implies every stage is full and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with an empty stage");

   // a valid response never carries the spare verdict code
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_INSIDE || rsp_verdict == VERDICT_INTERSECT ||
                     rsp_verdict == VERDICT_OUTSIDE))
      else $error("response verdict out of range");

   // a point is never reported as intersecting
   a_point_binary: assert property (@(posedge clock) disable iff (reset)
      (en4 && v3_ff && kind3_ff == KIND_POINT) |=> (rsp_verdict != VERDICT_INTERSECT))
      else $error("point classified as intersecting");

   // a sphere is never reported as inside
   a_sphere_never_in: assert property (@(posedge clock) disable iff (reset)
      (en4 && v3_ff && kind3_ff == KIND_SPHERE) |=> (rsp_verdict != VERDICT_INSIDE))
      else $error("sphere classified as inside");

endmodule

// ===== rtl/fcull_plane.sv =====
// ----------------------------------------------------------------------------
// fcull_plane
// Three-stage test of one primitive against one plane: products, sums,
// sign compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcull_plane (
   input  logic                                  clock,
   input  fcull_pkg::stage_en_type               stage_en,
   input  logic [fcull_pkg::CSR_DATA_W-1:0]      plane,
   input  fcull_pkg::kind_type                   kind,
   input  logic signed [fcull_pkg::COORD_W-1:0]  center_x,
   input  logic signed [fcull_pkg::COORD_W-1:0]  center_y,
   input  logic signed [fcull_pkg::COORD_W-1:0]  center_z,
   input  logic [fcull_pkg::HALF_W-1:0]          half_x,
   input  logic [fcull_pkg::HALF_W-1:0]          half_y,
   input  logic [fcull_pkg::HALF_W-1:0]          half_z,
   input  logic [fcull_pkg::HALF_W-1:0]          radius,
   output logic                                  outside,
   output logic                                  partial
);
   import fcull_pkg::*;

   logic signed [COEF_W-1:0] coef_a, coef_b, coef_c, coef_d;
   logic [COEF_W-1:0]        abs_a, abs_b, abs_c;

   // stage 1
   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;
   logic [ABSP_W-1:0]        na_ff, nb_ff, nc_ff, na_in, nb_in, nc_in;
   logic signed [COEF_W-1:0] d1_ff;
   logic [HALF_W-1:0]        rad1_ff;
   kind_type                 kind1_ff;
   // stage 2
   logic signed [M_W-1:0]    m_ff, m_in;
   logic [SLACK_W-1:0]       slack_ff, slack_in;
   // stage 3
   logic                     outside_ff, partial_ff;
   logic signed [CMP_W-1:0]  hi_sum, lo_sum;

   assign coef_a = plane[15:0];
   assign coef_b = plane[31:16];
   assign coef_c = plane[47:32];
   assign coef_d = plane[63:48];

   // magnitude as unsigned, so the most negative code maps to 2^15
   assign abs_a = coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
   assign abs_b = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
   assign abs_c = coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;

   assign pa_in = coef_a * center_x;
   assign pb_in = coef_b * center_y;
   assign pc_in = coef_c * center_z;
   assign na_in = half_x * abs_a;
   assign nb_in = half_y * abs_b;
   assign nc_in = half_z * abs_c;

   always_ff @(posedge clock) begin
      if (stage_en.en1) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         pc_ff    <= pc_in;
         na_ff    <= na_in;
         nb_ff    <= nb_in;
         nc_ff    <= nc_in;
         d1_ff    <= coef_d;
         rad1_ff  <= radius;
         kind1_ff <= kind;
      end
   end

   assign m_in = M_W'(pa_ff) + M_W'(pb_ff) + M_W'(pc_ff) + (M_W'(d1_ff) <<< FRAC_ALIGN);

   always_comb begin
      unique case (kind1_ff)
         KIND_POINT:  slack_in = '0;
         KIND_SPHERE: slack_in = SLACK_W'(rad1_ff) << FRAC_ALIGN;
         default:     slack_in = SLACK_W'(na_ff) + SLACK_W'(nb_ff) + SLACK_W'(nc_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en.en2) begin
         m_ff     <= m_in;
         slack_ff <= slack_in;
      end
   end

   // slack is zero for a point, so both compares reduce to m < 0
   assign hi_sum = CMP_W'(m_ff) + $signed({1'b0, slack_ff});
   assign lo_sum = CMP_W'(m_ff) - $signed({1'b0, slack_ff});

   always_ff @(posedge clock) begin
      if (stage_en.en3) begin
         outside_ff <= hi_sum[CMP_W-1];
         partial_ff <= lo_sum[CMP_W-1];
      end
   end

   assign outside = outside_ff;
   assign partial = partial_ff;

endmodule
